// ----- design/pctd_pkg.sv -----
// Package for the prime counter: widths, microcode types and the control store.
`timescale 1ns / 1ps

package pctd_pkg;

    // Width of the limit field.
    localparam int LIMIT_WIDTH = 12;
    // The candidate runs one past the limit, and the divisor square one step past it.
    localparam int K_WIDTH = LIMIT_WIDTH + 1;
    localparam int SQ_WIDTH = LIMIT_WIDTH + 1;
    localparam int COUNT_WIDTH = 10;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    // The remainder unit retires one dividend bit per cycle.
    localparam int DIV_CNT_WIDTH = $clog2(LIMIT_WIDTH + 1);
    localparam logic [DIV_CNT_WIDTH-1:0] DIV_STEPS = DIV_CNT_WIDTH'(LIMIT_WIDTH);

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic rem_zero;
    } rem_stat_t;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        S_WAIT_IN   = 4'd0,
        S_CHK_ZERO  = 4'd1,
        S_LOOP_K    = 4'd2,
        S_TEST_SQ   = 4'd3,
        S_DIV_START = 4'd4,
        S_DIV_WAIT  = 4'd5,
        S_CHK_REM   = 4'd6,
        S_STEP_D    = 4'd7,
        S_PRIME     = 4'd8,
        S_NEXT_K    = 4'd9,
        S_DONE      = 4'd10,
        S_ERR       = 4'd11
    } step_t;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_ALWAYS      = 3'd0,
        C_NO_ACCEPT   = 3'd1,
        C_N_ZERO      = 3'd2,
        C_K_GT_N      = 3'd3,
        C_SQ_GT_K     = 3'd4,
        C_DIV_BUSY    = 3'd5,
        C_REM_ZERO    = 3'd6,
        C_OUT_BLOCKED = 3'd7
    } cond_t;

    // One control word: datapath strobes, a condition and two successors.
    typedef struct packed {
        logic  ready;
        logic  init_d;
        logic  div_start;
        logic  step_d;
        logic  inc_count;
        logic  inc_k;
        logic  res_load;
        logic  res_bad;
        cond_t cond;
        step_t t_addr;
        step_t f_addr;
    } uword_t;

    // Control store.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '0;
        w.cond = C_ALWAYS;
        w.t_addr = S_WAIT_IN;
        w.f_addr = S_WAIT_IN;
        case (s)
            S_WAIT_IN:
            begin
                w.ready = 1'b1;
                w.cond = C_NO_ACCEPT;
                w.t_addr = S_WAIT_IN;
                w.f_addr = S_CHK_ZERO;
            end
            S_CHK_ZERO:
            begin
                w.cond = C_N_ZERO;
                w.t_addr = S_ERR;
                w.f_addr = S_LOOP_K;
            end
            S_LOOP_K:
            begin
                w.init_d = 1'b1;
                w.cond = C_K_GT_N;
                w.t_addr = S_DONE;
                w.f_addr = S_TEST_SQ;
            end
            S_TEST_SQ:
            begin
                w.cond = C_SQ_GT_K;
                w.t_addr = S_PRIME;
                w.f_addr = S_DIV_START;
            end
            S_DIV_START:
            begin
                w.div_start = 1'b1;
                w.t_addr = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                w.cond = C_DIV_BUSY;
                w.t_addr = S_DIV_WAIT;
                w.f_addr = S_CHK_REM;
            end
            S_CHK_REM:
            begin
                w.cond = C_REM_ZERO;
                w.t_addr = S_NEXT_K;
                w.f_addr = S_STEP_D;
            end
            S_STEP_D:
            begin
                w.step_d = 1'b1;
                w.t_addr = S_TEST_SQ;
            end
            S_PRIME:
            begin
                w.inc_count = 1'b1;
                w.t_addr = S_NEXT_K;
            end
            S_NEXT_K:
            begin
                w.inc_k = 1'b1;
                w.t_addr = S_LOOP_K;
            end
            S_DONE:
            begin
                w.res_load = 1'b1;
                w.cond = C_OUT_BLOCKED;
                w.t_addr = S_DONE;
                w.f_addr = S_WAIT_IN;
            end
            S_ERR:
            begin
                w.res_load = 1'b1;
                w.res_bad = 1'b1;
                w.cond = C_OUT_BLOCKED;
                w.t_addr = S_ERR;
                w.f_addr = S_WAIT_IN;
            end
            default:
            begin
                w.t_addr = S_WAIT_IN;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/pctd_if.sv -----
// Valid/ready channel interfaces for the limit input and the count result.
`timescale 1ns / 1ps

interface pctd_in_if;
    logic                             valid;
    logic                             ready;
    logic [pctd_pkg::LIMIT_WIDTH-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink (input valid, input limit, output ready);
endinterface

interface pctd_out_if;
    logic                             valid;
    logic                             ready;
    logic [pctd_pkg::COUNT_WIDTH-1:0] prime_count;
    logic                             bad_limit;

    modport source (output valid, output prime_count, output bad_limit, input ready);
    modport sink (input valid, input prime_count, input bad_limit, output ready);
endinterface

// ----- design/prime_count_trial_division.sv -----
// Top level of the prime counter: microcoded sequencer over a trial-division datapath.
`timescale 1ns / 1ps

//  Channel  Role    Payload                              Transfer when
//  item     sink    limit[11:0]                          item.valid && item.ready
//  result   source  prime_count[9:0], bad_limit          result.valid && result.ready
//
//  From the transfer of a limit n > 0 to its result, each k = 2..n is tested by trial division.
//  The trial divisors of k run from 2 up to the first factor or sqrt(k); a trial runs the
//  square test, the start of the bit-serial remainder unit, the wait while it is busy, the
//  remainder check and the divisor step, which it skips when it finds a factor. A limit of
//  zero is rejected. Reset clears the step counter, the remainder unit and the result flag.
//  A waiting result stalls only the last step; the next limit is taken once it leaves.

module prime_count_trial_division (
    input  logic              clk,
    input  logic              rst_n,
    pctd_in_if.sink           item,
    pctd_out_if.source        result
);

    // Sequencer state and the current control word.
    pctd_pkg::step_t upc_reg, upc_next;
    pctd_pkg::uword_t uw;
    logic cond_true;

    // Datapath registers.
    logic [pctd_pkg::LIMIT_WIDTH-1:0] n_reg, n_next;
    logic [pctd_pkg::K_WIDTH-1:0]     k_reg, k_next;
    logic [pctd_pkg::LIMIT_WIDTH-1:0] d_reg, d_next;
    logic [pctd_pkg::SQ_WIDTH-1:0]    sq_reg, sq_next;
    logic [pctd_pkg::COUNT_WIDTH-1:0] count_reg, count_next;

    // Output register.
    logic                             res_valid_reg, res_valid_next;
    logic [pctd_pkg::COUNT_WIDTH-1:0] res_count_reg, res_count_next;
    logic                             res_bad_reg, res_bad_next;

    logic accept;
    logic out_blocked;
    pctd_pkg::rem_stat_t rem_stat;

    assign accept = item.valid && item.ready;
    // The output register cannot take a new result while the old one is still waiting.
    assign out_blocked = res_valid_reg && !result.ready;

    pctd_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (uw.div_start),
        .dividend (k_reg[pctd_pkg::LIMIT_WIDTH-1:0]),
        .divisor  (d_reg),
        .stat     (rem_stat)
    );

    // Output decode: the control word for the current step drives the handshake.
    always_comb
    begin
        uw = pctd_pkg::ucode(upc_reg);
        item.ready = uw.ready;
    end

    // Next-step logic: every word branches two ways on one condition.
    always_comb
    begin
        case (uw.cond)
            pctd_pkg::C_ALWAYS:      cond_true = 1'b1;
            pctd_pkg::C_NO_ACCEPT:   cond_true = !accept;
            pctd_pkg::C_N_ZERO:      cond_true = (n_reg == '0);
            pctd_pkg::C_K_GT_N:      cond_true = (k_reg > {1'b0, n_reg});
            pctd_pkg::C_SQ_GT_K:     cond_true = (sq_reg > k_reg);
            pctd_pkg::C_DIV_BUSY:    cond_true = rem_stat.busy;
            pctd_pkg::C_REM_ZERO:    cond_true = rem_stat.rem_zero;
            pctd_pkg::C_OUT_BLOCKED: cond_true = out_blocked;
            default:                 cond_true = 1'b1;
        endcase
        upc_next = cond_true ? uw.t_addr : uw.f_addr;
    end

    // Datapath: each strobe of the control word updates one group of registers.
    always_comb
    begin
        n_next = n_reg;
        k_next = k_reg;
        d_next = d_reg;
        sq_next = sq_reg;
        count_next = count_reg;
        if (accept)
        begin
            n_next = item.limit;
            k_next = pctd_pkg::K_WIDTH'(2);
            count_next = '0;
        end
        if (uw.init_d)
        begin
            d_next = pctd_pkg::LIMIT_WIDTH'(2);
            sq_next = pctd_pkg::SQ_WIDTH'(4);
        end
        if (uw.step_d)
        begin
            // (d + 1)^2 = d^2 + 2d + 1 keeps the square without a multiplier.
            sq_next = sq_reg + {d_reg, 1'b1};
            d_next = d_reg + pctd_pkg::LIMIT_WIDTH'(1);
        end
        if (uw.inc_count && (count_reg != pctd_pkg::COUNT_MAX))
        begin
            count_next = count_reg + pctd_pkg::COUNT_WIDTH'(1);
        end
        if (uw.inc_k)
        begin
            k_next = k_reg + pctd_pkg::K_WIDTH'(1);
        end
    end

    // Result register: loaded by the last step once the previous result has left.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_count_next = res_count_reg;
        res_bad_next = res_bad_reg;
        if (result.valid && result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (uw.res_load && !out_blocked)
        begin
            res_valid_next = 1'b1;
            // The count is still zero on the bad-limit path.
            res_count_next = count_reg;
            res_bad_next = uw.res_bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pctd_pkg::S_WAIT_IN;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        k_reg <= k_next;
        d_reg <= d_next;
        sq_reg <= sq_next;
        count_reg <= count_next;
        res_count_reg <= res_count_next;
        res_bad_reg <= res_bad_next;
    end

    assign result.valid = res_valid_reg;
    assign result.prime_count = res_count_reg;
    assign result.bad_limit = res_bad_reg;

`ifndef SYNTHESIS
    // A rejected limit always reports a count of zero.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.bad_limit) |-> (result.prime_count == '0))
        else $error("bad limit result carries a nonzero count");
    // The remainder unit only runs while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.busy |-> (upc_reg == pctd_pkg::S_DIV_WAIT))
        else $error("remainder unit busy outside its wait step");
    // The running square matches the divisor whenever it is compared.
    a_square: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == pctd_pkg::S_TEST_SQ) |->
            (sq_reg == (pctd_pkg::SQ_WIDTH'(d_reg) * pctd_pkg::SQ_WIDTH'(d_reg))))
        else $error("divisor square out of step with divisor");
    // The candidate never runs more than one past the limit.
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == pctd_pkg::S_LOOP_K) |-> (k_reg <= ({1'b0, n_reg} + pctd_pkg::K_WIDTH'(1))))
        else $error("candidate ran past the limit");
`endif

endmodule

// ----- design/pctd_rem.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module pctd_rem (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [pctd_pkg::LIMIT_WIDTH-1:0] dividend,
    input  logic [pctd_pkg::LIMIT_WIDTH-1:0] divisor,
    output pctd_pkg::rem_stat_t              stat
);

    logic                               busy_reg, busy_next;
    logic [pctd_pkg::DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [pctd_pkg::LIMIT_WIDTH-1:0]   rem_reg, rem_next;
    logic [pctd_pkg::LIMIT_WIDTH-1:0]   dvd_reg, dvd_next;
    logic [pctd_pkg::LIMIT_WIDTH-1:0]   dsr_reg, dsr_next;
    logic [pctd_pkg::LIMIT_WIDTH:0]     trial;

    assign trial = {rem_reg, dvd_reg[pctd_pkg::LIMIT_WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = pctd_pkg::DIV_STEPS;
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = pctd_pkg::LIMIT_WIDTH'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[pctd_pkg::LIMIT_WIDTH-1:0];
            end
            dvd_next = {dvd_reg[pctd_pkg::LIMIT_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - pctd_pkg::DIV_CNT_WIDTH'(1);
            if (cnt_reg == pctd_pkg::DIV_CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.rem_zero = (rem_reg == '0);

`ifndef SYNTHESIS
    // The step counter is nonzero exactly while the unit works.
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("remainder unit busy with an exhausted step counter");
    // A run lasts the full number of steps before it ends.
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(cnt_reg) == pctd_pkg::DIV_CNT_WIDTH'(1)))
        else $error("remainder unit ended early");
    // The partial remainder always stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !$rose(busy_reg)) |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule
